### sv/environmental_sensor_compensation_assert.svh
// Assertion macros shared by the sensor compensation checker.
`ifndef ENVIRONMENTAL_SENSOR_COMPENSATION_ASSERT_SVH
`define ENVIRONMENTAL_SENSOR_COMPENSATION_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low.
`define ESC_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off while rst_ni is low.
`define ESC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/esc_pkg.sv
// Types, constants and register codes of the sensor compensation block.
`default_nettype none
package esc_pkg;

  localparam int unsigned RegCount = 6;
  localparam int unsigned AddrW    = 6;
  localparam int unsigned DataW    = 64;
  localparam int unsigned DivW     = 64;

  // divider: one operand stage, one stage per quotient bit, one sign stage
  localparam int unsigned DivLatency    = DivW + 2;
  localparam int unsigned DivInStage    = 12;
  localparam int unsigned FinalStage    = DivInStage + DivLatency + 6;
  // clock edges from the accepting edge to the edge that takes the result
  localparam int unsigned ResultLatency = FinalStage + 2;

  localparam logic [16:0] HumQ10Max = 17'd102400;

  typedef enum logic [2:0] {
    REG_TEMP    = 3'd0,
    REG_PRESS_A = 3'd1,
    REG_PRESS_B = 3'd2,
    REG_PRESS_C = 3'd3,
    REG_HUM_A   = 3'd4,
    REG_HUM_B   = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
    logic [15:0] raw_humidity;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] temperature_centi;
    logic [31:0]        pressure_pa;
    logic [16:0]        humidity_q10;
    logic               pressure_invalid;
  } result_t;

  // raw coefficient bits; sign is applied where they are used
  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
    logic [7:0]  h1;
    logic [15:0] h2;
    logic [15:0] h3;
    logic [15:0] h4;
    logic [15:0] h5;
    logic [15:0] h6;
  } coeff_t;

endpackage
`default_nettype wire

### sv/esc_delay.sv
// Fixed-length register delay line for pipeline alignment.
`default_nettype none
module esc_delay #(
  parameter int unsigned Width = esc_pkg::DataW,
  parameter int unsigned Depth = 1
) (
  input  logic             clk_i,
  input  logic [Width-1:0] d_i,
  output logic [Width-1:0] q_o
);

  logic [Width-1:0] line_q [Depth];

  always_ff @(posedge clk_i) begin
    line_q[0] <= d_i;
    for (int i = 1; i < Depth; i++) begin
      line_q[i] <= line_q[i-1];
    end
  end

  assign q_o = line_q[Depth-1];

endmodule
`default_nettype wire

### sv/esc_mul64.sv
// Two-stage 64x64 multiplier, low 64 bits of the product (wraps).
`default_nettype none
module esc_mul64 (
  input  logic        clk_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] ll_d, ll_q;
  logic [31:0] lh_q, hl_q;
  logic [63:0] p_q;

  assign ll_d = {32'b0, a_i[31:0]} * {32'b0, b_i[31:0]};

  always_ff @(posedge clk_i) begin
    ll_q <= ll_d;
    lh_q <= a_i[31:0] * b_i[63:32];
    hl_q <= a_i[63:32] * b_i[31:0];
    p_q  <= ll_q + {lh_q + hl_q, 32'b0};
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

### sv/esc_sdiv64.sv
// Pipelined signed 64-bit divider, truncating, one quotient bit per stage.
`default_nettype none
module esc_sdiv64 (
  input  logic                     clk_i,
  input  logic [esc_pkg::DivW-1:0] num_i,
  input  logic [esc_pkg::DivW-1:0] den_i,
  output logic [esc_pkg::DivW-1:0] quo_o
);

  localparam int unsigned W = esc_pkg::DivW;

  logic [W-1:0] rem_q [W+1];
  logic [W-1:0] nq_q  [W+1];
  logic [W-1:0] den_q [W+1];
  logic         neg_q [W+1];
  logic [W-1:0] rem_d [W];
  logic [W-1:0] nq_d  [W];
  logic [W-1:0] quo_q;

  // restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    for (int s = 0; s < W; s++) begin
      logic [W-1:0] shifted;
      logic [W:0]   diff;
      shifted = {rem_q[s][W-2:0], nq_q[s][W-1]};
      diff    = {1'b0, shifted} - {1'b0, den_q[s]};
      if (!diff[W]) begin
        rem_d[s] = diff[W-1:0];
        nq_d[s]  = {nq_q[s][W-2:0], 1'b1};
      end else begin
        rem_d[s] = shifted;
        nq_d[s]  = {nq_q[s][W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= '0;
    nq_q[0]  <= num_i[W-1] ? (~num_i + W'(1)) : num_i;
    den_q[0] <= den_i[W-1] ? (~den_i + W'(1)) : den_i;
    neg_q[0] <= num_i[W-1] ^ den_i[W-1];
    for (int s = 0; s < W; s++) begin
      rem_q[s+1] <= rem_d[s];
      nq_q[s+1]  <= nq_d[s];
      den_q[s+1] <= den_q[s];
      neg_q[s+1] <= neg_q[s];
    end
    quo_q <= neg_q[W] ? (~nq_q[W] + W'(1)) : nq_q[W];
  end

  assign quo_o = quo_q;

endmodule
`default_nettype wire

### sv/esc_apb_regs.sv
// APB register file holding the calibration coefficients.
`default_nettype none
module esc_apb_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [esc_pkg::AddrW-1:0] paddr,
  input  logic [esc_pkg::DataW-1:0] pwdata,
  output logic [esc_pkg::DataW-1:0] prdata,
  output esc_pkg::coeff_t           coeff_o
);

  logic [47:0]       regs_q [esc_pkg::RegCount];
  esc_pkg::reg_idx_e idx;
  logic              wr_en;

  assign idx   = esc_pkg::reg_idx_e'(paddr[esc_pkg::AddrW-1:3]);
  assign wr_en = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < esc_pkg::RegCount; i++) begin
        regs_q[i] <= '0;
      end
    end else if (wr_en) begin
      unique case (idx)
        esc_pkg::REG_TEMP:    regs_q[esc_pkg::REG_TEMP]    <= pwdata[47:0];
        esc_pkg::REG_PRESS_A: regs_q[esc_pkg::REG_PRESS_A] <= pwdata[47:0];
        esc_pkg::REG_PRESS_B: regs_q[esc_pkg::REG_PRESS_B] <= pwdata[47:0];
        esc_pkg::REG_PRESS_C: regs_q[esc_pkg::REG_PRESS_C] <= pwdata[47:0];
        esc_pkg::REG_HUM_A:   regs_q[esc_pkg::REG_HUM_A]   <= {8'b0, pwdata[39:0]};
        esc_pkg::REG_HUM_B:   regs_q[esc_pkg::REG_HUM_B]   <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      esc_pkg::REG_TEMP:    prdata = {16'b0, regs_q[esc_pkg::REG_TEMP]};
      esc_pkg::REG_PRESS_A: prdata = {16'b0, regs_q[esc_pkg::REG_PRESS_A]};
      esc_pkg::REG_PRESS_B: prdata = {16'b0, regs_q[esc_pkg::REG_PRESS_B]};
      esc_pkg::REG_PRESS_C: prdata = {16'b0, regs_q[esc_pkg::REG_PRESS_C]};
      esc_pkg::REG_HUM_A:   prdata = {16'b0, regs_q[esc_pkg::REG_HUM_A]};
      esc_pkg::REG_HUM_B:   prdata = {16'b0, regs_q[esc_pkg::REG_HUM_B]};
      default:              prdata = '0;
    endcase
  end

  assign coeff_o.t1 = regs_q[esc_pkg::REG_TEMP][15:0];
  assign coeff_o.t2 = regs_q[esc_pkg::REG_TEMP][31:16];
  assign coeff_o.t3 = regs_q[esc_pkg::REG_TEMP][47:32];
  assign coeff_o.p1 = regs_q[esc_pkg::REG_PRESS_A][15:0];
  assign coeff_o.p2 = regs_q[esc_pkg::REG_PRESS_A][31:16];
  assign coeff_o.p3 = regs_q[esc_pkg::REG_PRESS_A][47:32];
  assign coeff_o.p4 = regs_q[esc_pkg::REG_PRESS_B][15:0];
  assign coeff_o.p5 = regs_q[esc_pkg::REG_PRESS_B][31:16];
  assign coeff_o.p6 = regs_q[esc_pkg::REG_PRESS_B][47:32];
  assign coeff_o.p7 = regs_q[esc_pkg::REG_PRESS_C][15:0];
  assign coeff_o.p8 = regs_q[esc_pkg::REG_PRESS_C][31:16];
  assign coeff_o.p9 = regs_q[esc_pkg::REG_PRESS_C][47:32];
  assign coeff_o.h1 = regs_q[esc_pkg::REG_HUM_A][7:0];
  assign coeff_o.h2 = regs_q[esc_pkg::REG_HUM_A][23:8];
  assign coeff_o.h3 = regs_q[esc_pkg::REG_HUM_A][39:24];
  assign coeff_o.h4 = regs_q[esc_pkg::REG_HUM_B][15:0];
  assign coeff_o.h5 = regs_q[esc_pkg::REG_HUM_B][31:16];
  assign coeff_o.h6 = regs_q[esc_pkg::REG_HUM_B][47:32];

endmodule
`default_nettype wire

### sv/environmental_sensor_compensation.sv
// Top level: pipelined temperature, pressure and humidity compensation.
//
// Usage:
//  - Input channel: drive sample_i and raise start; the transaction is taken
//    at a rising edge with start high and busy low. busy is high only during
//    reset and in the cycle after its release, so one sample set can enter every cycle.
//  - Output channel: strobe_o marks result_o for exactly one cycle. There is
//    no backpressure; the receiver must take each result as it comes.
//  - Result path: each accepted sample set passes through the pipelined
//    pressure divider plus the multiply stages around it.
//  - Throughput: one sample set per cycle, sustained while busy is low.
//  - Config: APB, 64-bit data, register i at byte 8*i. Write coefficients
//    only while no transaction is in flight; they feed every stage directly.
//  - Reset: clears the coefficients to zero and drops all in-flight work
//    (valid bits clear); payload registers are not reset.
//  - A zero pressure divisor gives pressure_pa = 0 with pressure_invalid set.
`default_nettype none
module environmental_sensor_compensation (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  esc_pkg::sample_t          sample_i,
  output logic                      strobe_o,
  output esc_pkg::result_t          result_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [esc_pkg::AddrW-1:0] paddr,
  input  logic [esc_pkg::DataW-1:0] pwdata,
  output logic [esc_pkg::DataW-1:0] prdata,
  output logic                      pready
);

  localparam int unsigned FinalStage = esc_pkg::FinalStage;
  localparam int unsigned DivOut     = esc_pkg::DivInStage + esc_pkg::DivLatency;

  localparam logic [31:0] TempRound    = 32'd128;
  localparam logic [63:0] PressTOfs    = 64'd128000;
  localparam logic [63:0] PressRawOfs  = 64'd1048576;
  localparam logic [63:0] PressScale   = 64'd3125;
  localparam logic [63:0] PressBias    = 64'd1 << 47;
  localparam logic [31:0] HumTOfs      = 32'd76800;
  localparam logic [31:0] HumRound     = 32'd16384;
  localparam logic [31:0] HumHbOfs     = 32'd32768;
  localparam logic [31:0] HumHqOfs     = 32'd2097152;
  localparam logic [31:0] HumHrRound   = 32'd8192;
  localparam logic [31:0] HumQ22Max    = 32'd419430400;

  function automatic logic [31:0] sx16to32(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [63:0] sx16to64(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [63:0] sx32to64(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned n);
    return 32'($signed(v) >>> n);
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] v, input int unsigned n);
    return 64'($signed(v) >>> n);
  endfunction

  // --------------------------------------------------------------------
  // Handshake and valid line
  // --------------------------------------------------------------------
  logic                  accept;
  logic                  busy_q;
  logic [FinalStage+1:0] vld_q;

  assign accept = start & ~busy_q;
  assign busy   = busy_q;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      vld_q  <= '0;
    end else begin
      busy_q <= 1'b0;
      vld_q  <= {vld_q[FinalStage:0], accept};
    end
  end

  assign strobe_o = vld_q[FinalStage+1];

  // --------------------------------------------------------------------
  // Coefficients
  // --------------------------------------------------------------------
  esc_pkg::coeff_t coeff;

  esc_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .coeff_o (coeff)
  );

  // stage 0: input capture
  esc_pkg::sample_t in_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= sample_i;
    end
  end

  // --------------------------------------------------------------------
  // Temperature, 32-bit wrap (stages 1..4)
  // --------------------------------------------------------------------
  logic [31:0] ta, tb;
  logic [31:0] ma_q, mbb_q, v1_q, mt_q, tfine_q, temp_q;
  logic [63:0] q1_q;
  logic [31:0] hx_q;

  assign ta = {15'b0, in_q.raw_temperature[19:3]} - {15'b0, coeff.t1, 1'b0};
  assign tb = {16'b0, in_q.raw_temperature[19:4]} - {16'b0, coeff.t1};

  always_ff @(posedge clk_i) begin
    ma_q    <= ta * sx16to32(coeff.t2);
    mbb_q   <= tb * tb;
    v1_q    <= asr32(ma_q, 11);
    mt_q    <= asr32(mbb_q, 12) * sx16to32(coeff.t3);
    tfine_q <= v1_q + asr32(mt_q, 14);
    temp_q  <= asr32((tfine_q << 2) + tfine_q + TempRound, 8);
    q1_q    <= sx32to64(tfine_q) - PressTOfs;
    hx_q    <= tfine_q - HumTOfs;
  end

  // --------------------------------------------------------------------
  // Pressure, 64-bit wrap
  // --------------------------------------------------------------------
  logic [63:0] sq, q1p5, q1p2, sqp6, sqp3, q1p5_d, q1p2_d;
  logic [63:0] q2_q, q1b_q, m6, den, den_q, num0_q, num;
  logic [19:0] rp_d;
  logic [63:0] pdiff;
  logic        bad, bad_d;

  // stages 4 -> 6
  esc_mul64 u_mul_sq   (.clk_i(clk_i), .a_i(q1_q), .b_i(q1_q),                 .p_o(sq));
  esc_mul64 u_mul_q1p5 (.clk_i(clk_i), .a_i(q1_q), .b_i(sx16to64(coeff.p5)),   .p_o(q1p5));
  esc_mul64 u_mul_q1p2 (.clk_i(clk_i), .a_i(q1_q), .b_i(sx16to64(coeff.p2)),   .p_o(q1p2));
  // stages 6 -> 8
  esc_mul64 u_mul_sqp6 (.clk_i(clk_i), .a_i(sq),   .b_i(sx16to64(coeff.p6)),   .p_o(sqp6));
  esc_mul64 u_mul_sqp3 (.clk_i(clk_i), .a_i(sq),   .b_i(sx16to64(coeff.p3)),   .p_o(sqp3));

  esc_delay #(.Width(64), .Depth(2)) u_dly_q1p5 (.clk_i(clk_i), .d_i(q1p5), .q_o(q1p5_d));
  esc_delay #(.Width(64), .Depth(2)) u_dly_q1p2 (.clk_i(clk_i), .d_i(q1p2), .q_o(q1p2_d));
  esc_delay #(.Width(20), .Depth(9)) u_dly_rp
    (.clk_i(clk_i), .d_i(in_q.raw_pressure), .q_o(rp_d));

  assign pdiff = PressRawOfs - {44'b0, rp_d};

  // stage 9: q2 and the biased divisor term; stage 10: numerator before scale
  always_ff @(posedge clk_i) begin
    q2_q   <= sqp6 + (q1p5_d << 17) + (sx16to64(coeff.p4) << 35);
    q1b_q  <= asr64(sqp3, 8) + (q1p2_d << 12) + PressBias;
    num0_q <= (pdiff << 31) - q2_q;
  end

  // stages 9 -> 11: divisor; 10 -> 12: numerator
  esc_mul64 u_mul_p1  (.clk_i(clk_i), .a_i(q1b_q),  .b_i({48'b0, coeff.p1}), .p_o(m6));
  esc_mul64 u_mul_scl (.clk_i(clk_i), .a_i(num0_q), .b_i(PressScale),        .p_o(num));

  assign den = asr64(m6, 33);
  assign bad = (den == '0);

  always_ff @(posedge clk_i) begin
    den_q <= den;
  end

  esc_delay #(.Width(1), .Depth(FinalStage - 11)) u_dly_bad
    (.clk_i(clk_i), .d_i(bad), .q_o(bad_d));

  // stages 12 -> DivOut
  logic [63:0] quo, s13, m8, m9, m10, q2e, q2e_d, p_d;
  logic [63:0] psum_q, pf_q;

  esc_sdiv64 u_div (.clk_i(clk_i), .num_i(num), .den_i(den_q), .quo_o(quo));

  assign s13 = asr64(quo, 13);

  esc_mul64 u_mul_ss  (.clk_i(clk_i), .a_i(s13), .b_i(s13),                .p_o(m8));
  esc_mul64 u_mul_p8  (.clk_i(clk_i), .a_i(quo), .b_i(sx16to64(coeff.p8)), .p_o(m9));
  esc_mul64 u_mul_p9  (.clk_i(clk_i), .a_i(m8),  .b_i(sx16to64(coeff.p9)), .p_o(m10));

  assign q2e = asr64(m9, 19);

  esc_delay #(.Width(64), .Depth(2)) u_dly_q2e (.clk_i(clk_i), .d_i(q2e), .q_o(q2e_d));
  esc_delay #(.Width(64), .Depth(4)) u_dly_p   (.clk_i(clk_i), .d_i(quo), .q_o(p_d));

  // stages DivOut+5 and DivOut+6
  always_ff @(posedge clk_i) begin
    psum_q <= p_d + asr64(m10, 25) + q2e_d;
    pf_q   <= asr64(psum_q, 8) + (sx16to64(coeff.p7) << 4);
  end

  // --------------------------------------------------------------------
  // Humidity, 32-bit wrap (stages 5..14)
  // --------------------------------------------------------------------
  logic [15:0] rh_d;
  logic [31:0] mh5_q, mh6_q, mh3_q, hp_q, ha_q, hb_q, hqm_q, hq_q, hrm_q, hr_q;
  logic [31:0] hp_d, x2_q, x2_d, ysq_q, th_q, x3, y;
  logic [16:0] hum_d, hum_q, hum_dd;

  esc_delay #(.Width(16), .Depth(5)) u_dly_rh
    (.clk_i(clk_i), .d_i(in_q.raw_humidity), .q_o(rh_d));
  esc_delay #(.Width(32), .Depth(4)) u_dly_hp (.clk_i(clk_i), .d_i(hp_q), .q_o(hp_d));
  esc_delay #(.Width(32), .Depth(2)) u_dly_x2 (.clk_i(clk_i), .d_i(x2_q), .q_o(x2_d));

  assign y  = asr32(x2_q, 15);
  assign x3 = x2_d - asr32(th_q, 4);

  always_ff @(posedge clk_i) begin
    mh5_q <= sx16to32(coeff.h5) * hx_q;
    mh6_q <= hx_q * sx16to32(coeff.h6);
    mh3_q <= hx_q * sx16to32(coeff.h3);
    hp_q  <= asr32(({16'b0, rh_d} << 14) - (sx16to32(coeff.h4) << 20) - mh5_q + HumRound,
                   15);
    ha_q  <= asr32(mh6_q, 10);
    hb_q  <= asr32(mh3_q, 11) + HumHbOfs;
    hqm_q <= ha_q * hb_q;
    hq_q  <= asr32(hqm_q, 10) + HumHqOfs;
    hrm_q <= hq_q * sx16to32(coeff.h2);
    hr_q  <= asr32(hrm_q + HumHrRound, 14);
    x2_q  <= hp_d * hr_q;
    ysq_q <= y * y;
    th_q  <= asr32(ysq_q, 7) * {24'b0, coeff.h1};
    hum_q <= hum_d;
  end

  // clamp to 0..100 %RH, then drop to Q7.10
  always_comb begin
    if (x3[31]) begin
      hum_d = '0;
    end else if (x3 > HumQ22Max) begin
      hum_d = esc_pkg::HumQ10Max;
    end else begin
      hum_d = x3[28:12];
    end
  end

  // --------------------------------------------------------------------
  // Alignment to the final stage and result register
  // --------------------------------------------------------------------
  logic [31:0] temp_d;

  esc_delay #(.Width(32), .Depth(FinalStage - 4)) u_dly_temp
    (.clk_i(clk_i), .d_i(temp_q), .q_o(temp_d));
  esc_delay #(.Width(17), .Depth(FinalStage - 14)) u_dly_hum
    (.clk_i(clk_i), .d_i(hum_q), .q_o(hum_dd));

  esc_pkg::result_t result_q;
  logic [63:0]      pres;

  assign pres = asr64(pf_q, 8);

  always_ff @(posedge clk_i) begin
    result_q.temperature_centi <= $signed(temp_d);
    result_q.pressure_pa       <= bad_d ? 32'd0 : pres[31:0];
    result_q.humidity_q10      <= hum_dd;
    result_q.pressure_invalid  <= bad_d;
  end

  assign result_o = result_q;

  // stage bookkeeping: divider output lands at DivOut, psum at DivOut+5
  if (DivOut + 6 != FinalStage) begin : g_bad_schedule
    esc_delay #(.Width(1), .Depth(1)) u_never (.clk_i(clk_i), .d_i(1'b0), .q_o());
  end

endmodule
`default_nettype wire

### sv/esc_assert_chk.sv
// Port-level checker for the sensor compensation block, with its bind.
`default_nettype none
`include "environmental_sensor_compensation_assert.svh"
module esc_assert_chk (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             strobe_i,
  input esc_pkg::result_t result_i
);

  `ESC_ASSERT_IMPL(a_result_has_source, strobe_i, $past(start && !busy, esc_pkg::ResultLatency), "result without a matching transaction")
  `ESC_ASSERT_IMPL(a_source_has_result, $past(start && !busy, esc_pkg::ResultLatency), strobe_i, "transaction produced no result")
  `ESC_ASSERT_IMPL(a_invalid_zero, strobe_i && result_i.pressure_invalid, result_i.pressure_pa == 32'd0, "invalid pressure not zero")
  `ESC_ASSERT_IMPL(a_hum_range, strobe_i, result_i.humidity_q10 <= esc_pkg::HumQ10Max, "humidity above full scale")
  `ESC_ASSERT_NEXT(a_stays_ready, !busy, !busy, "busy raised after reset")

endmodule

bind environmental_sensor_compensation esc_assert_chk u_esc_assert_chk (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .strobe_i (strobe_o),
  .result_i (result_o)
);
`default_nettype wire
